// File: rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Field widths, status codes and reset constants for the block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int REQ_W    = 1;
  localparam int MARGIN_W = 9;
  localparam int BLKIDX_W = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  localparam int MAX_BLOCKS       = 256;
  localparam int NUM_BLOCKS_RESET = 256;

  localparam logic [REQ_W-1:0] REQ_GET = 1'b0;
  localparam logic [REQ_W-1:0] REQ_PUT = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD_INDEX = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_POOL_FULL = 2'd3;

endpackage

// File: rtl/core/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block allocator with the free list held as a link memory.
// ----------------------------------------------------------------------------
// A request (get or put) is taken when start is high and busy is low and
// passes through the accept cycle, during which the link memory is read
// at the current head, and an execute cycle that updates head, counts and
// the link memory. The result is presented on the following cycle with done
// high for exactly one cycle; done is not held, so capture it when done is seen.
// A new request may be issued in that same cycle; busy holds off a new request
// until the last one has executed. After reset and after every num_blocks write
// the free list is rebuilt by a sweep that writes one link per cycle, with busy
// high throughout.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            num_blocks_we,
  input  logic [fbpa_pkg::COUNT_W-1:0]    num_blocks,
  input  logic                            start,
  output logic                            busy,
  input  logic [fbpa_pkg::REQ_W-1:0]      req_type,
  input  logic [fbpa_pkg::MARGIN_W-1:0]   margin,
  input  logic [fbpa_pkg::BLKIDX_W-1:0]   block_index,
  output logic                            done,
  output logic [fbpa_pkg::STATUS_W-1:0]   status,
  output logic [fbpa_pkg::BLKIDX_W-1:0]   granted_index,
  output logic [fbpa_pkg::COUNT_W-1:0]    free_count,
  output logic [fbpa_pkg::COUNT_W-1:0]    min_free
);

  import fbpa_pkg::*;

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int LW = $clog2(MAX_BLOCKS + 2);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int NB_RESET = (NUM_BLOCKS_RESET > MAX_BLOCKS) ? MAX_BLOCKS : NUM_BLOCKS_RESET;

  localparam logic [LW-1:0] LINK_END   = LW'(MAX_BLOCKS);
  localparam logic [LW-1:0] LINK_TAKEN = LW'(MAX_BLOCKS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;

  logic [1:0]          state;
  logic [CW-1:0]       nb;
  logic [LW-1:0]       head;
  logic [CW-1:0]       free_blocks;
  logic [CW-1:0]       low_water;
  logic [IW-1:0]       sweep_idx;
  logic [REQ_W-1:0]    r_req;
  logic [MARGIN_W-1:0] r_margin;
  logic [BLKIDX_W-1:0] r_blk;

  logic                we;
  logic [IW-1:0]       waddr;
  logic [LW-1:0]       wdata;
  logic [LW-1:0]       rdata;

  logic [CW-1:0]       nb_clamped;
  logic [CW:0]         sweep_nxt;
  logic                get_ok;
  logic                put_full;
  logic                put_bad;
  logic [CW-1:0]       free_dec;

  fbpa_ram #(.WIDTH(LW), .DEPTH(MAX_BLOCKS)) u_links (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (head[IW-1:0]),
    .rdata (rdata)
  );

  assign busy = (state != S_IDLE);

  always_comb begin
    if (num_blocks == '0) begin
      nb_clamped = CW'(1);
    end else if (32'(num_blocks) > MAX_BLOCKS) begin
      nb_clamped = CW'(MAX_BLOCKS);
    end else begin
      nb_clamped = CW'(num_blocks);
    end
  end

  assign sweep_nxt = (CW+1)'(sweep_idx) + (CW+1)'(1);
  assign free_dec  = free_blocks - CW'(1);

  assign get_ok   = (32'(free_blocks) > 32'(r_margin)) && (32'(head) < MAX_BLOCKS);
  assign put_full = (free_blocks >= nb);
  assign put_bad  = (32'(r_blk) >= 32'(nb));

  // Link memory write: rebuild chain during sweep, request update in execute.
  always_comb begin
    we    = 1'b0;
    waddr = sweep_idx;
    wdata = LINK_END;
    unique case (state)
      S_SWEEP: begin
        we    = 1'b1;
        waddr = sweep_idx;
        wdata = (sweep_nxt < (CW+1)'(nb)) ? LW'(sweep_nxt) : LINK_END;
      end
      S_EXEC: begin
        if (r_req == REQ_GET) begin
          we    = get_ok;
          waddr = head[IW-1:0];
          wdata = LINK_TAKEN;
        end else begin
          we    = !put_full && !put_bad;
          waddr = IW'(r_blk);
          wdata = head;
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      nb          <= CW'(NB_RESET);
      head        <= '0;
      free_blocks <= CW'(NB_RESET);
      low_water   <= CW'(NB_RESET);
      sweep_idx   <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      if (num_blocks_we) begin
        state       <= S_SWEEP;
        nb          <= nb_clamped;
        head        <= '0;
        free_blocks <= nb_clamped;
        low_water   <= nb_clamped;
        sweep_idx   <= '0;
      end else begin
        unique case (state)
          S_SWEEP: begin
            sweep_idx <= IW'(sweep_nxt);
            if (sweep_nxt == (CW+1)'(nb)) begin
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (start) begin
              state <= S_EXEC;
            end
          end
          S_EXEC: begin
            state <= S_IDLE;
            done  <= 1'b1;
            if (r_req == REQ_GET) begin
              if (get_ok) begin
                head        <= rdata;
                free_blocks <= free_dec;
                if (low_water > free_dec) begin
                  low_water <= free_dec;
                end
              end
            end else if (!put_full && !put_bad) begin
              head        <= LW'(r_blk);
              free_blocks <= free_blocks + CW'(1);
            end
          end
          default: begin
            state <= S_IDLE;
          end
        endcase
      end
    end
  end

  // Request capture and result payload.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      r_req    <= req_type;
      r_margin <= margin;
      r_blk    <= block_index;
    end
    if (state == S_EXEC) begin
      granted_index <= '0;
      if (r_req == REQ_GET) begin
        if (get_ok) begin
          status        <= STATUS_OK;
          granted_index <= BLKIDX_W'(head);
          free_count    <= COUNT_W'(free_dec);
          min_free      <= COUNT_W'((low_water > free_dec) ? free_dec : low_water);
        end else begin
          status     <= STATUS_REFUSED;
          free_count <= COUNT_W'(free_blocks);
          min_free   <= COUNT_W'(low_water);
        end
      end else begin
        min_free <= COUNT_W'(low_water);
        if (put_full) begin
          status     <= STATUS_POOL_FULL;
          free_count <= COUNT_W'(free_blocks);
        end else if (put_bad) begin
          status     <= STATUS_BAD_INDEX;
          free_count <= COUNT_W'(free_blocks);
        end else begin
          status     <= STATUS_OK;
          free_count <= COUNT_W'(free_blocks + CW'(1));
        end
      end
    end
  end

  a_done_after_exec: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == S_EXEC))
    else $error("result beat without an execute cycle");

  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    free_blocks <= nb)
    else $error("free count above pool size");

  a_low_water: assert property (@(posedge clk) disable iff (rst)
    low_water <= free_blocks)
    else $error("low-water mark above free count");

  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) |-> busy)
    else $error("request window open during rebuild");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fixed_block_pool_allocator. Gets and puts go in
// with random gaps. A free-list predictor works out each expected reply and
// a ledger compares it with the reply that comes out on done. The run covers
// pool sizes from one block to the full pool, including out-of-range writes.
// ----------------------------------------------------------------------------

localparam int POOL_DEPTH = 256;
localparam logic [8:0] LINK_END   = 9'd256;
localparam logic [8:0] LINK_TAKEN = 9'd257;

typedef struct packed {
  logic [fbpa_pkg::STATUS_W-1:0] status;
  logic [fbpa_pkg::BLKIDX_W-1:0] granted_index;
  logic [fbpa_pkg::COUNT_W-1:0]  free_count;
  logic [fbpa_pkg::COUNT_W-1:0]  min_free;
} pool_reply_t;

class pool_ledger;
  logic [8:0] links [POOL_DEPTH];
  logic [8:0] head_q;
  logic [8:0] free_q;
  logic [8:0] low_q;
  logic [8:0] pool_size;
  pool_reply_t pending_replies [$];
  int errors;

  function new();
    errors = 0;
    rebuild(9'(fbpa_pkg::NUM_BLOCKS_RESET));
  endfunction

  // Clamp the size and chain the blocks of the pool in order, ending in the end mark.
  function void rebuild(logic [8:0] value);
    if (value == 9'd0) pool_size = 9'd1;
    else if (value > 9'(POOL_DEPTH)) pool_size = 9'(POOL_DEPTH);
    else pool_size = value;
    for (int i = 0; i < POOL_DEPTH; i++) begin
      links[i] = (i + 1 < pool_size) ? 9'(i + 1) : LINK_END;
    end
    head_q = 9'd0;
    free_q = pool_size;
    low_q = pool_size;
  endfunction

  function pool_reply_t take_request(logic req, logic [8:0] margin, logic [7:0] idx);
    pool_reply_t want;
    want = '0;
    want.status = fbpa_pkg::STATUS_OK;
    if (req == fbpa_pkg::REQ_GET) begin
      // A head that is no block means the list is broken: refuse.
      if (free_q > margin && head_q < 9'(POOL_DEPTH)) begin
        want.granted_index = head_q[7:0];
        head_q = links[want.granted_index];
        links[want.granted_index] = LINK_TAKEN;
        free_q = free_q - 9'd1;
        if (low_q > free_q) low_q = free_q;
      end else begin
        want.status = fbpa_pkg::STATUS_REFUSED;
      end
    end else if (free_q >= pool_size) begin
      want.status = fbpa_pkg::STATUS_POOL_FULL;
    end else if ({1'b0, idx} >= pool_size) begin
      want.status = fbpa_pkg::STATUS_BAD_INDEX;
    end else begin
      links[idx] = head_q;
      head_q = {1'b0, idx};
      free_q = free_q + 9'd1;
    end
    want.free_count = free_q;
    want.min_free = low_q;
    pending_replies.push_back(want);
    return want;
  endfunction

  task report(string what);
    $display("%0t mismatch: %s", $time, what);
    errors++;
  endtask

  task check_field(string name, int got, int want);
    if (got != want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  task match_reply(pool_reply_t got);
    pool_reply_t want;
    if (pending_replies.size() == 0) begin
      report($sformatf("reply with no request pending: status %0d index %0d",
                       got.status, got.granted_index));
    end else begin
      want = pending_replies.pop_front();
      check_field("status", int'(got.status), int'(want.status));
      check_field("granted_index", int'(got.granted_index), int'(want.granted_index));
      check_field("free_count", int'(got.free_count), int'(want.free_count));
      check_field("min_free", int'(got.min_free), int'(want.min_free));
    end
  endtask
endclass

module testbench;
  import fbpa_pkg::*;

  localparam int GAP_MAX      = 11;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int TAIL_CYCLES  = 10;

  logic                clk;
  logic                rst;
  logic                num_blocks_we;
  logic [COUNT_W-1:0]  num_blocks;
  logic                start;
  logic                busy;
  logic [REQ_W-1:0]    req_type;
  logic [MARGIN_W-1:0] margin;
  logic [BLKIDX_W-1:0] block_index;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [BLKIDX_W-1:0] granted_index;
  logic [COUNT_W-1:0]  free_count;
  logic [COUNT_W-1:0]  min_free;

  pool_ledger  ledger;
  logic [7:0]  held_blocks [$];
  bit          eager;
  int          cycle_count = 0;
  pool_reply_t seen_reply;

  fixed_block_pool_allocator dut (
    .clk           (clk),
    .rst           (rst),
    .num_blocks_we (num_blocks_we),
    .num_blocks    (num_blocks),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .margin        (margin),
    .block_index   (block_index),
    .done          (done),
    .status        (status),
    .granted_index (granted_index),
    .free_count    (free_count),
    .min_free      (min_free)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("fixed_block_pool_allocator regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) begin
      seen_reply.status = status;
      seen_reply.granted_index = granted_index;
      seen_reply.free_count = free_count;
      seen_reply.min_free = min_free;
      ledger.match_reply(seen_reply);
    end
  end

  // Hold start until the beat is taken, then predict and track held blocks.
  task issue_request(input logic req, input logic [8:0] m, input logic [7:0] idx,
                     output pool_reply_t want);
    int gap;
    int pos;
    gap = eager ? 0 : int'($urandom_range(0, GAP_MAX));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req_type <= req;
    margin <= m;
    block_index <= idx;
    do @(posedge clk); while (busy);
    want = ledger.take_request(req, m, idx);
    if (want.status == STATUS_OK) begin
      if (req == REQ_GET) begin
        held_blocks.push_back(want.granted_index);
      end else begin
        pos = -1;
        foreach (held_blocks[k]) if (held_blocks[k] == idx && pos < 0) pos = k;
        if (pos >= 0) held_blocks.delete(pos);
      end
    end
  endtask

  // Drain all replies, then write the size; the block rebuilds its list.
  task resize_pool(input logic [8:0] value);
    start <= 1'b0;
    while (ledger.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    num_blocks_we <= 1'b1;
    num_blocks <= value;
    ledger.rebuild(value);
    held_blocks.delete();
    @(posedge clk);
    num_blocks_we <= 1'b0;
  endtask

  task run_directed();
    pool_reply_t want;
    eager = 1'b0;
    issue_request(REQ_PUT, 9'd0, 8'd0, want);
    issue_request(REQ_GET, 9'd256, 8'd0, want);
    issue_request(REQ_GET, 9'h1FF, 8'hFF, want);
    issue_request(REQ_GET, 9'd255, 8'd0, want);
    issue_request(REQ_GET, 9'd0, 8'd0, want);
    // Push a block that is already free; the pool does not notice.
    issue_request(REQ_PUT, 9'd0, 8'd255, want);
    issue_request(REQ_PUT, 9'd0, 8'd1, want);
    issue_request(REQ_PUT, 9'd0, 8'd0, want);
    resize_pool(9'd3);
    repeat (4) issue_request(REQ_GET, 9'd0, 8'd0, want);
    issue_request(REQ_PUT, 9'd0, 8'd3, want);
    issue_request(REQ_PUT, 9'h1FF, 8'd255, want);
    issue_request(REQ_PUT, 9'd0, 8'd2, want);
    issue_request(REQ_PUT, 9'd0, 8'd2, want);
    issue_request(REQ_GET, 9'd0, 8'd0, want);
    issue_request(REQ_GET, 9'd1, 8'd0, want);
    resize_pool(9'd0);
    issue_request(REQ_GET, 9'd0, 8'd0, want);
    issue_request(REQ_GET, 9'd0, 8'd0, want);
    issue_request(REQ_PUT, 9'd0, 8'd0, want);
    issue_request(REQ_PUT, 9'd0, 8'd0, want);
  endtask

  // Alternate between draining the pool and filling it back, mostly with
  // blocks actually held, plus double puts and bad indexes.
  task run_phase(input logic [8:0] size_value, input int count);
    int n;
    int roll;
    bit filling;
    logic req;
    logic [8:0] m;
    logic [7:0] idx;
    pool_reply_t want;
    resize_pool(size_value);
    if (size_value == 9'd0) n = 1;
    else if (size_value > 9'(POOL_DEPTH)) n = POOL_DEPTH;
    else n = int'(size_value);
    eager = ($urandom_range(0, 3) == 0);
    filling = 1'b1;
    repeat (count) begin
      roll = int'($urandom_range(0, 9));
      req = (filling ? (roll < 8) : (roll < 2)) ? REQ_GET : REQ_PUT;
      roll = int'($urandom_range(0, 9));
      if (req == REQ_GET) begin
        if (roll < 6) m = 9'd0;
        else if (roll < 8) m = 9'($urandom_range(0, n));
        else if (roll == 8) m = 9'($urandom_range(0, 511));
        else m = 9'd256;
        idx = 8'($urandom_range(0, 255));
      end else begin
        m = 9'($urandom_range(0, 511));
        if (roll < 7 && held_blocks.size() > 0)
          idx = held_blocks[$urandom_range(0, held_blocks.size() - 1)];
        else if (roll < 8) idx = 8'($urandom_range(0, n - 1));
        else if (roll == 8 && n < POOL_DEPTH) idx = 8'($urandom_range(n, 255));
        else idx = 8'($urandom_range(0, 255));
      end
      issue_request(req, m, idx, want);
      if (want.status == STATUS_REFUSED) filling = 1'b0;
      else if (want.status == STATUS_POOL_FULL || held_blocks.size() == 0) filling = 1'b1;
    end
  endtask

  initial begin
    ledger = new();
    clk = 1'b0;
    rst = 1'b1;
    num_blocks_we = 1'b0;
    num_blocks = 9'(NUM_BLOCKS_RESET);
    start = 1'b0;
    req_type = REQ_GET;
    margin = '0;
    block_index = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_phase(9'd4, 40);
    run_phase(9'd1, 30);
    run_phase(9'd256, 60);
    run_phase(9'd0, 20);
    run_phase(9'd2, 40);
    run_phase(9'h1FF, 30);
    run_phase(9'd17, 50);
    run_phase(9'($urandom_range(1, 32)), 50);
    run_phase(9'd255, 40);
    run_phase(9'($urandom_range(0, 511)), 40);
    start <= 1'b0;
    while (ledger.pending_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.errors == 0)
      $display("fixed_block_pool_allocator regression: pass");
    else
      $display("fixed_block_pool_allocator regression: fail");
    $finish;
  end

endmodule
